/* hdl/stored_container_deframer_crc32_unit_assert.svh */
// Assertion macros for the stored container deframer.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef STORED_CONTAINER_DEFRAMER_CRC32_UNIT_ASSERT_SVH
`define STORED_CONTAINER_DEFRAMER_CRC32_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SCDC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/scdc_pkg.sv */
// Shared types, constants and the CRC-32 byte update for the container deframer.
// No dependencies; used by scdc_core, scdc_out_fifo and the top level.
package scdc_pkg;

  localparam int unsigned HDR_LEN_POS = 5;
  localparam int unsigned HDR_CRC_POS = 13;
  localparam int unsigned HDR_TOTAL   = 17;
  localparam int unsigned HDR_CNT_W   = 5;

  localparam logic [3:0][7:0] MAGIC = {8'h54, 8'h4F, 8'h52, 8'h42};
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [31:0] CAP_RESET = 32'hFFFFFFFF;

  localparam int unsigned LEN_W   = 64;
  localparam int unsigned TDATA_W = 80;
  localparam int unsigned FIELD_W = 8 + 3 + LEN_W;
  localparam int unsigned PAD_W   = TDATA_W - FIELD_W;

  // Power of two so the pointers wrap on their own.
  localparam int unsigned OUT_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_TOO_SHORT = 3'd2,
    ST_BAD_MAGIC = 3'd3,
    ST_OVER_CAP  = 3'd4,
    ST_TRUNCATED = 3'd5,
    ST_CRC_BAD   = 3'd6
  } scdc_status_e;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [7:0]       payload_byte;
    logic [2:0]       status;
    logic [LEN_W-1:0] payload_length;
    logic             end_of_run;
  } scdc_result_t;

  typedef struct packed {
    logic         pay_valid;
    logic         stat_valid;
    scdc_result_t pay;
    scdc_result_t stat;
  } scdc_push_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hdl/scdc_core.sv */
// Header capture, payload gating, CRC-32 and status decision for one byte.
// Depends on scdc_pkg and the assertion macro header.
`include "stored_container_deframer_crc32_unit_assert.svh"

module scdc_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic [7:0]                byte_i,
  input  logic                      last_i,
  input  logic [31:0]               capacity_i,
  output scdc_pkg::scdc_push_t      push_o
);

  localparam int unsigned CW = scdc_pkg::HDR_CNT_W;
  localparam logic [CW-1:0] CNT_LEN   = CW'(scdc_pkg::HDR_LEN_POS);
  localparam logic [CW-1:0] CNT_CRC   = CW'(scdc_pkg::HDR_CRC_POS);
  localparam logic [CW-1:0] CNT_TOTAL = CW'(scdc_pkg::HDR_TOTAL);
  localparam logic [CW-1:0] CNT_MAGIC = CW'(4);

  logic [CW-1:0]                  hdr_cnt_q, hdr_cnt_d;
  logic                           magic_good_q, magic_good_d;
  logic [scdc_pkg::LEN_W-1:0]     stored_len_q, stored_len_d;
  logic [31:0]                    stored_crc_q, stored_crc_d;
  logic [31:0]                    crc_q, crc_d;
  logic [scdc_pkg::LEN_W-1:0]     rem_q, rem_d;

  logic [2:0]    len_off;
  logic [1:0]    crc_off;
  logic          pay_hit, over_cap;
  logic          n_full, n_min_len;
  logic [2:0]    status;

  assign len_off = 3'(hdr_cnt_q - CNT_LEN);
  assign crc_off = 2'(hdr_cnt_q - CNT_CRC);
  assign pay_hit = (hdr_cnt_q == CNT_TOTAL) && (rem_q != '0);

  always_comb begin
    magic_good_d = magic_good_q;
    stored_len_d = stored_len_q;
    stored_crc_d = stored_crc_q;
    if (hdr_cnt_q < CNT_MAGIC) begin
      if (byte_i != scdc_pkg::MAGIC[hdr_cnt_q[1:0]]) magic_good_d = 1'b0;
    end else if (hdr_cnt_q >= CNT_LEN && hdr_cnt_q < CNT_CRC) begin
      stored_len_d[{len_off, 3'b000} +: 8] = byte_i;
    end else if (hdr_cnt_q >= CNT_CRC && hdr_cnt_q < CNT_TOTAL) begin
      stored_crc_d[{crc_off, 3'b000} +: 8] = byte_i;
    end
  end

  always_comb begin
    if (hdr_cnt_q == CNT_TOTAL - CW'(1)) begin
      rem_d = stored_len_q;
    end else if (pay_hit) begin
      rem_d = rem_q - scdc_pkg::LEN_W'(1);
    end else begin
      rem_d = rem_q;
    end
  end

  assign crc_d     = pay_hit ? scdc_pkg::crc_byte(crc_q, byte_i) : crc_q;
  assign hdr_cnt_d = (hdr_cnt_q == CNT_TOTAL) ? hdr_cnt_q : hdr_cnt_q + CW'(1);
  assign n_full    = (hdr_cnt_d == CNT_TOTAL);
  assign n_min_len = (hdr_cnt_d >= CNT_CRC);
  assign over_cap  = (stored_len_d[scdc_pkg::LEN_W-1:32] != '0) ||
                     (stored_len_d[31:0] > capacity_i);

  always_comb begin
    if (!n_full) begin
      status = scdc_pkg::ST_TOO_SHORT;
    end else if (!magic_good_d) begin
      status = scdc_pkg::ST_BAD_MAGIC;
    end else if (over_cap) begin
      status = scdc_pkg::ST_OVER_CAP;
    end else if (rem_d != '0) begin
      status = scdc_pkg::ST_TRUNCATED;
    end else if ((crc_d ^ scdc_pkg::CRC_INIT) != stored_crc_d) begin
      status = scdc_pkg::ST_CRC_BAD;
    end else begin
      status = scdc_pkg::ST_OK;
    end
    if (status != scdc_pkg::ST_OK && n_min_len && stored_len_d == '0) begin
      status = scdc_pkg::ST_EMPTY;
    end
  end

  always_comb begin
    push_o.pay_valid = advance_i && pay_hit && !over_cap;
    push_o.stat_valid = advance_i && last_i;
    push_o.pay.kind = scdc_pkg::KIND_PAYLOAD;
    push_o.pay.payload_byte = byte_i;
    push_o.pay.status = scdc_pkg::ST_OK;
    push_o.pay.payload_length = '0;
    push_o.pay.end_of_run = 1'b0;
    push_o.stat.kind = scdc_pkg::KIND_STATUS;
    push_o.stat.payload_byte = '0;
    push_o.stat.status = status;
    push_o.stat.payload_length = (status == scdc_pkg::ST_OK) ? stored_len_d : '0;
    push_o.stat.end_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q    <= '0;
      magic_good_q <= 1'b1;
      stored_len_q <= '0;
      stored_crc_q <= '0;
      crc_q        <= scdc_pkg::CRC_INIT;
      rem_q        <= '0;
    end else if (advance_i) begin
      if (last_i) begin
        hdr_cnt_q    <= '0;
        magic_good_q <= 1'b1;
        stored_len_q <= '0;
        stored_crc_q <= '0;
        crc_q        <= scdc_pkg::CRC_INIT;
        rem_q        <= '0;
      end else begin
        hdr_cnt_q    <= hdr_cnt_d;
        magic_good_q <= magic_good_d;
        stored_len_q <= stored_len_d;
        stored_crc_q <= stored_crc_d;
        crc_q        <= crc_d;
        rem_q        <= rem_d;
      end
    end
  end

  `SCDC_ASSERT_NOW(a_pay_after_hdr, clk_i, rst_ni, push_o.pay_valid,
                   hdr_cnt_q == CNT_TOTAL, "payload forwarded inside header")
  `SCDC_ASSERT_NEXT(a_clear_on_last, clk_i, rst_ni, advance_i && last_i,
                    hdr_cnt_q == '0 && crc_q == scdc_pkg::CRC_INIT && rem_q == '0,
                    "run state not cleared after last byte")
  `SCDC_ASSERT_NOW(a_rem_only_payload, clk_i, rst_ni, rem_q != '0,
                   hdr_cnt_q == CNT_TOTAL, "remaining count set before header end")

endmodule

/* hdl/scdc_out_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on scdc_pkg and the assertion macro header.
`include "stored_container_deframer_crc32_unit_assert.svh"

module scdc_out_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  scdc_pkg::scdc_push_t    push_i,
  output logic                    room_o,
  output logic                    valid_o,
  input  logic                    ready_i,
  output scdc_pkg::scdc_result_t  head_o
);

  localparam int unsigned DEPTH = scdc_pkg::OUT_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  scdc_pkg::scdc_result_t mem [DEPTH];

  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d, wr_alt;
  logic [CNT_W-1:0] count_q, count_d, push_n;
  logic             pop;

  assign valid_o = (count_q != '0);
  assign head_o  = mem[rd_ptr_q];
  assign room_o  = (count_q <= CNT_W'(DEPTH - 2));
  assign pop     = valid_o && ready_i;
  assign push_n  = CNT_W'(push_i.pay_valid) + CNT_W'(push_i.stat_valid);
  assign wr_alt  = wr_ptr_q + PTR_W'(1);

  assign rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
  assign wr_ptr_d = wr_ptr_q + PTR_W'(push_n);
  assign count_d  = count_q + push_n - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.pay_valid) mem[wr_ptr_q] <= push_i.pay;
    if (push_i.stat_valid) mem[push_i.pay_valid ? wr_alt : wr_ptr_q] <= push_i.stat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  `SCDC_ASSERT_NOW(a_no_overflow, clk_i, rst_ni, push_n != '0,
                   (count_q - CNT_W'(pop) + push_n) <= CNT_W'(DEPTH), "result queue overflow")
  `SCDC_ASSERT_NOW(a_ptr_track, clk_i, rst_ni, 1'b1,
                   wr_ptr_q == PTR_W'(rd_ptr_q + PTR_W'(count_q)),
                   "queue pointers and count disagree")
  `SCDC_ASSERT_NEXT(a_count_step, clk_i, rst_ni, 1'b1,
                    count_q == CNT_W'($past(count_q) + $past(push_n) - CNT_W'($past(pop))),
                    "queue count step wrong")

endmodule

/* hdl/stored_container_deframer_crc32_unit.sv */
// Top level of the stored container deframer with CRC-32 check.
// Depends on scdc_pkg, scdc_core and scdc_out_fifo.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata: data_byte, tlast: is_last
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata: byte/status/length, tuser, tlast
//  cfg       in         cfg_valid_i/cfg_ready_o       cfg_data_i: output_capacity
//
// One byte per cycle sustained while the result queue has room; a byte is first registered,
// then decoded and written into the result queue, which drives m_axis.
// A closing byte that also carries payload queues two results; the 4-entry result queue
// drains one per cycle, so input stalls only while downstream holds m_axis_tready low.
// Reset clears the run state and sets output_capacity to all ones; no clearing pass.
module stored_container_deframer_crc32_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tlast,  // is_last
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [scdc_pkg::TDATA_W-1:0]  m_axis_tdata,  // [7:0] payload_byte, [10:8] status,
                                                       // [74:11] payload_length, rest zero
  output logic                          m_axis_tuser,  // kind
  output logic                          m_axis_tlast,  // end_of_run
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [31:0]                   cfg_data_i
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic [31:0] capacity_q;
  logic        room, advance;

  scdc_pkg::scdc_push_t   push;
  scdc_pkg::scdc_result_t head;

  assign advance       = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign in_valid_d    = s_axis_tvalid ? 1'b1 : (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      capacity_q <= scdc_pkg::CAP_RESET;
    end else begin
      if (s_axis_tready) in_valid_q <= in_valid_d;
      if (cfg_valid_i && cfg_ready_o) capacity_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  scdc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .byte_i     (in_byte_q),
    .last_i     (in_last_q),
    .capacity_i (capacity_q),
    .push_o     (push)
  );

  scdc_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = {{scdc_pkg::PAD_W{1'b0}}, head.payload_length, head.status,
                         head.payload_byte};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.end_of_run;

endmodule

/* tb/sv/tb_stored_container_deframer_crc32_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for stored_container_deframer_crc32_unit: streams containers
// byte by byte, predicts payload and status transactions, and compares them field by field.
// Depends on scdc_pkg and the RTL of the deframer.
module tb_stored_container_deframer_crc32_unit;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fixed;
    logic [2:0] st;
  } dir_row_t;

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata = 8'h00;
  logic                          s_axis_tlast = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [scdc_pkg::TDATA_W-1:0]  m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          m_axis_tlast;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [31:0]                   cfg_data_i = 32'h0;

  stored_container_deframer_crc32_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Deframer state mirror.
  logic [31:0] capacity;
  logic [63:0] run_bytes;
  logic        magic_ok;
  logic [63:0] hdr_length;
  logic [31:0] hdr_crc;
  logic [31:0] payload_crc;
  logic [31:0] crc_lut [256];

  scdc_pkg::scdc_result_t pending_results [$];
  scdc_pkg::scdc_result_t want;
  logic [7:0]   stim_data [$];
  logic         stim_last [$];

  int errors = 0;
  int bytes_sent = 0;
  int runs_built = 0;
  int payload_checked = 0;
  int status_seen [8];
  int burst_left = 0;
  int seg_left = 0;
  int rx_mode = 0;
  int rx_hold = 0;

  dir_row_t dir_rows [19] = '{
    '{8'h00, 1'b1, 1'b1, scdc_pkg::ST_TOO_SHORT},
    '{8'hFF, 1'b0, 1'b0, scdc_pkg::ST_OK}, '{8'hFF, 1'b0, 1'b0, scdc_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, scdc_pkg::ST_OK}, '{8'hFF, 1'b0, 1'b0, scdc_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, scdc_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, scdc_pkg::ST_OK}, '{8'h00, 1'b0, 1'b0, scdc_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, scdc_pkg::ST_OK}, '{8'h00, 1'b0, 1'b0, scdc_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, scdc_pkg::ST_OK}, '{8'h00, 1'b0, 1'b0, scdc_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, scdc_pkg::ST_OK}, '{8'h00, 1'b1, 1'b1, scdc_pkg::ST_EMPTY},
    '{8'h42, 1'b0, 1'b0, scdc_pkg::ST_OK}, '{8'h52, 1'b0, 1'b0, scdc_pkg::ST_OK},
    '{8'h4F, 1'b0, 1'b0, scdc_pkg::ST_OK}, '{8'h54, 1'b0, 1'b0, scdc_pkg::ST_OK},
    '{8'h80, 1'b1, 1'b1, scdc_pkg::ST_TOO_SHORT}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[stored_container_deframer_crc32_unit] ERROR");
    $finish;
  end

  function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
    return (c >> 8) ^ crc_lut[c[7:0] ^ b];
  endfunction

  function automatic void clear_run_state();
    run_bytes   = '0;
    magic_ok    = 1'b1;
    hdr_length  = '0;
    hdr_crc     = '0;
    payload_crc = scdc_pkg::CRC_INIT;
  endfunction

  // Advance the mirror by one accepted byte and queue the transactions it causes.
  function automatic void deframe_byte(input logic [7:0] b, input logic last);
    logic [63:0]            idx;
    logic [63:0]            n;
    scdc_pkg::scdc_status_e st;
    idx = run_bytes;
    if (idx < 4) begin
      if (b != scdc_pkg::MAGIC[idx[1:0]]) magic_ok = 1'b0;
    end else if (idx >= scdc_pkg::HDR_LEN_POS && idx < scdc_pkg::HDR_CRC_POS) begin
      hdr_length |= 64'(b) << (8 * (idx - scdc_pkg::HDR_LEN_POS));
    end else if (idx >= scdc_pkg::HDR_CRC_POS && idx < scdc_pkg::HDR_TOTAL) begin
      hdr_crc |= 32'(b) << (8 * (idx - scdc_pkg::HDR_CRC_POS));
    end else if (idx >= scdc_pkg::HDR_TOTAL && (idx - scdc_pkg::HDR_TOTAL) < hdr_length) begin
      payload_crc = crc_update(payload_crc, b);
      if (hdr_length <= {32'd0, capacity}) begin
        pending_results.push_back('{kind: scdc_pkg::KIND_PAYLOAD, payload_byte: b,
                                    status: scdc_pkg::ST_OK, payload_length: '0,
                                    end_of_run: 1'b0});
      end
    end
    n = (idx == '1) ? idx : idx + 64'd1;
    run_bytes = n;
    if (last) begin
      if (n < scdc_pkg::HDR_TOTAL) st = scdc_pkg::ST_TOO_SHORT;
      else if (!magic_ok) st = scdc_pkg::ST_BAD_MAGIC;
      else if (hdr_length > {32'd0, capacity}) st = scdc_pkg::ST_OVER_CAP;
      else if (n - scdc_pkg::HDR_TOTAL < hdr_length) st = scdc_pkg::ST_TRUNCATED;
      else if (~payload_crc != hdr_crc) st = scdc_pkg::ST_CRC_BAD;
      else st = scdc_pkg::ST_OK;
      if (st != scdc_pkg::ST_OK && n >= scdc_pkg::HDR_CRC_POS && hdr_length == 0) begin
        st = scdc_pkg::ST_EMPTY;
      end
      pending_results.push_back('{kind: scdc_pkg::KIND_STATUS, payload_byte: 8'h00,
                                  status: st,
                                  payload_length: (st == scdc_pkg::ST_OK) ? hdr_length : 64'd0,
                                  end_of_run: 1'b1});
      clear_run_state();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    deframe_byte(b, last);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end
  endtask

  // Hold the sender until every queued transaction has drained.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    capacity = v;
  endtask

  task automatic make_run();
    logic [7:0]  body [$];
    logic [7:0]  pay [$];
    logic [63:0] len;
    logic [31:0] crc;
    int          pick;
    int          plen;
    int          trail;
    int          cut;
    pick  = $urandom_range(0, 99);
    trail = 0;
    cut   = 0;
    runs_built++;
    if (pick >= 94) begin
      repeat ($urandom_range(1, 30)) begin
        stim_data.push_back(8'($urandom));
        stim_last.push_back(1'b0);
      end
      stim_last[$] = 1'b1;
      return;
    end
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 8);
    if (pick >= 88) plen = 0;
    if ({32'd0, capacity} < 64'(plen)) plen = int'(capacity);
    crc = scdc_pkg::CRC_INIT;
    repeat (plen) begin
      pay.push_back(8'($urandom));
      crc = crc_update(crc, pay[$]);
    end
    crc = ~crc;
    len = 64'(plen);
    if (pick >= 40 && pick < 48) begin
      trail = $urandom_range(1, 4);
    end else if (pick >= 56 && pick < 64) begin
      crc ^= $urandom_range(1, 32'hFFFF_FFFF);
    end else if (pick >= 64 && pick < 72) begin
      if ($urandom_range(0, 3) == 0) len = {1'b1, 31'($urandom), 32'($urandom)};
      else len = 64'(plen) + 64'($urandom_range(1, 4));
    end else if (pick >= 72 && pick < 80) begin
      if (capacity != '1) len = {32'd0, capacity} + 64'($urandom_range(1, 5));
      else len = {32'($urandom_range(1, 32'hFFFF)), 32'($urandom)};
    end else if (pick >= 80 && pick < 88) begin
      cut = $urandom_range(1, 16);
    end else if (pick >= 88) begin
      crc   = $urandom_range(0, 3) == 0 ? 32'd0 : 32'($urandom);
      trail = $urandom_range(0, 3);
      if ($urandom_range(0, 1) == 1) cut = $urandom_range(13, 16);
    end
    for (int i = 0; i < 4; i++) body.push_back(scdc_pkg::MAGIC[i]);
    body.push_back(8'($urandom));
    for (int i = 0; i < 8; i++) body.push_back(len[8*i +: 8]);
    for (int i = 0; i < 4; i++) body.push_back(crc[8*i +: 8]);
    foreach (pay[i]) body.push_back(pay[i]);
    repeat (trail) body.push_back(8'($urandom));
    if (pick >= 48 && pick < 56) body[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    if (pick >= 88 && $urandom_range(0, 1) == 1) body[0] ^= 8'h01;
    if (cut != 0) body = body[0:cut-1];
    foreach (body[i]) begin
      stim_data.push_back(body[i]);
      stim_last.push_back(i == body.size() - 1);
    end
  endtask

  // Receiver: alternate segments of full rate, random stalls and long stalls.
  always @(posedge clk_i) begin
    if (seg_left == 0) begin
      rx_mode  = $urandom_range(0, 2);
      seg_left = $urandom_range(20, 80);
    end else begin
      seg_left--;
    end
    if (rx_mode == 0) begin
      m_axis_tready <= 1'b1;
    end else if (rx_mode == 1) begin
      m_axis_tready <= 1'($urandom);
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      rx_hold = $urandom_range(1, 12);
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: tdata %h tuser %b tlast %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[7:0] !== want.payload_byte) begin
          $error("payload_byte: expected %h, got %h", want.payload_byte, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[10:8] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[10:8]);
          errors++;
        end
        if (m_axis_tdata[74:11] !== want.payload_length) begin
          $error("payload_length: expected %0d, got %0d", want.payload_length,
                 m_axis_tdata[74:11]);
          errors++;
        end
        if (m_axis_tlast !== want.end_of_run) begin
          $error("end_of_run: expected %0d, got %0d", want.end_of_run, m_axis_tlast);
          errors++;
        end
        if (m_axis_tdata[scdc_pkg::TDATA_W-1:scdc_pkg::FIELD_W] !== '0) begin
          $error("padding: expected 0, got %h",
                 m_axis_tdata[scdc_pkg::TDATA_W-1:scdc_pkg::FIELD_W]);
          errors++;
        end
        if (want.kind == scdc_pkg::KIND_STATUS) status_seen[want.status]++;
        else payload_checked++;
      end
    end
  end

  initial begin
    logic [31:0] cap_plan [5];
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = i;
      repeat (8) c = c[0] ? ((c >> 1) ^ scdc_pkg::CRC_POLY) : (c >> 1);
      crc_lut[i] = c;
    end
    foreach (status_seen[i]) status_seen[i] = 0;
    capacity = scdc_pkg::CAP_RESET;
    clear_run_state();
    cap_plan = '{32'd0, 32'd6, 32'($urandom), 32'hFFFF_FFFF, 32'd20};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].last);
      if (dir_rows[i].fixed) begin
        pending_results[$].status         = dir_rows[i].st;
        pending_results[$].payload_length = '0;
      end
      pace();
    end

    // A phase may end mid-run, so the next capacity applies to the rest of that run.
    foreach (cap_plan[p]) begin
      drain();
      write_capacity(cap_plan[p]);
      repeat (90) begin
        if (stim_data.size() == 0) make_run();
        send_byte(stim_data.pop_front(), stim_last.pop_front());
        pace();
      end
    end
    while (stim_data.size() != 0) begin
      send_byte(stim_data.pop_front(), stim_last.pop_front());
      pace();
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d bytes in %0d random runs plus directed headers, %0d capacity settings,",
             bytes_sent, runs_built, $size(cap_plan) + 1);
    $display({"checked %0d payload bytes; status ok %0d empty %0d short %0d magic %0d",
              " cap %0d trunc %0d crc %0d"},
             payload_checked, status_seen[scdc_pkg::ST_OK], status_seen[scdc_pkg::ST_EMPTY],
             status_seen[scdc_pkg::ST_TOO_SHORT], status_seen[scdc_pkg::ST_BAD_MAGIC],
             status_seen[scdc_pkg::ST_OVER_CAP], status_seen[scdc_pkg::ST_TRUNCATED],
             status_seen[scdc_pkg::ST_CRC_BAD]);
    if (errors == 0) begin
      $display("[stored_container_deframer_crc32_unit] OK");
    end else begin
      $display("[stored_container_deframer_crc32_unit] ERROR");
    end
    $finish;
  end

endmodule
